FILE: rtl/spi_eeprom_command_sequencer_core_defines.svh
// assertion macros shared by the sequencer rtl
`ifndef SPI_EEPROM_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define SPI_EEPROM_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SESC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SESC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sesc_pkg.sv
// types and constants of the spi eeprom command sequencer
package sesc_pkg;

	localparam int PAGE_BYTES = 256;
	localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
	localparam int ADDR_W     = 24;
	localparam int LEN_W      = 9;
	localparam int CNT_W      = 12;
	localparam int BUF_W      = 32;
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam int LIMIT_W    = 16;

	localparam logic [APB_ADDR_W-1:0] ADDR_POLL_LIMIT  = 2'd0;
	localparam logic [LIMIT_W-1:0]    POLL_LIMIT_RESET = 16'd1000;

	localparam logic [2:0] ACT_READ         = 3'd0;
	localparam logic [2:0] ACT_WRITE        = 3'd1;
	localparam logic [2:0] ACT_STATUS       = 3'd2;
	localparam logic [2:0] ACT_PRESENCE     = 3'd3;
	localparam logic [2:0] ACT_STATUS_REPLY = 3'd4;

	localparam logic [7:0] OP_WREN  = 8'h06;
	localparam logic [7:0] OP_WRDI  = 8'h04;
	localparam logic [7:0] OP_RDSR  = 8'h05;
	localparam logic [7:0] OP_READ  = 8'h03;
	localparam logic [7:0] OP_WRITE = 8'h02;

	localparam int         ST_WIP_BIT = 0;
	localparam int         ST_WEL_BIT = 1;
	localparam logic [7:0] ST_ALL_ONES = 8'hFF;

	localparam logic [3:0]       SPLIT_NIBBLE = 4'hC;
	localparam logic [LEN_W-1:0] SPLIT_HEAD   = 9'd4;

	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef struct packed {
		logic [2:0]       action;
		logic [ADDR_W-1:0] mem_address;
		logic [CNT_W-1:0] byte_count;
		logic [BUF_W-1:0] host_buffer;
		logic [7:0]       status_in;
	} req_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        opcode;
		logic [ADDR_W-1:0] out_address;
		logic [LEN_W-1:0]  data_bytes;
		logic [BUF_W-1:0]  out_buffer;
		logic [7:0]        status_value;
		logic              present;
		logic              refused;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [BUF_W-1:0]  buf_addr;
	} piece_t;

	typedef enum logic [2:0] {
		JOB_DONE       = 3'd0,
		JOB_READ       = 3'd1,
		JOB_RDSR       = 3'd2,
		JOB_PIECE      = 3'd3,
		JOB_PRES_START = 3'd4,
		JOB_PRES_END   = 3'd5
	} job_kind_t;

	typedef struct packed {
		job_kind_t  jkind;
		piece_t     piece;
		logic [7:0] status;
		logic       present;
		logic       refused;
	} job_t;

endpackage

FILE: rtl/sesc_req_if.sv
// request channel: valid, ready and one request item
interface sesc_req_if;
	import sesc_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/sesc_rsp_if.sv
// result channel: valid, ready and one result item
interface sesc_rsp_if;
	import sesc_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/spi_eeprom_command_sequencer_core.sv
// top level of the spi eeprom command sequencer
//
//  channel  dir  handshake             carries
//  req      in   valid/ready           action, mem_address, byte_count, host_buffer, status_in
//  rsp      out  valid/ready           kind, opcode, out_address, data_bytes, out_buffer,
//                                      status_value, present, refused, last
//  apb      in   psel/penable/pready   poll_limit at byte address 0
//
//  a request is taken whenever the job queue has room; it yields at most one job
//  the back end gives one result per cycle unless rsp stalls; a job gives 1 to 4 results (write piece: 4)
//  the sustained rate is set by that expander, which gives the most results for write pieces
//  reset is asynchronous and clears control state only; no clearing pass is needed
//  the output register holds a result under stall while the front end keeps accepting until the queue is full
module spi_eeprom_command_sequencer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sesc_req_if.sink                        req,
	sesc_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sesc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sesc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sesc_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import sesc_pkg::*;

	logic [LIMIT_W-1:0] poll_limit_q;
	logic               push_valid;
	job_t               push_job;
	logic               queue_full;
	logic               pop;
	logic               head_valid;
	job_t               head_job;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_POLL_LIMIT) ? APB_DATA_W'(poll_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_POLL_LIMIT)) begin
			poll_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	sesc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.poll_limit (poll_limit_q),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	sesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	sesc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

FILE: rtl/sesc_queue.sv
// job queue between the front end and the back end
`include "spi_eeprom_command_sequencer_core_defines.svh"
module sesc_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sesc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output sesc_pkg::job_t head_job
);
	import sesc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	job_t               mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;

	assign full       = (count_q == CNT_W_Q'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SESC_ASSERT_NOW(a_no_overflow, push && full, pop, "push into a full queue")
	`SESC_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

FILE: rtl/sesc_front.sv
// front end: takes requests and status replies, keeps the sequence state, queues jobs
`include "spi_eeprom_command_sequencer_core_defines.svh"
module sesc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	sesc_req_if.sink                     req,
	input  logic [sesc_pkg::LIMIT_W-1:0] poll_limit,
	input  logic                         queue_full,
	output logic                         push_valid,
	output sesc_pkg::job_t               push_job
);
	import sesc_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_WPOLL    = 4'b0010,
		PH_STATUS   = 4'b0100,
		PH_PRESENCE = 4'b1000
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [2:0]          total_q, total_d;
	logic [1:0]          pos_q, pos_d;
	logic [LIMIT_W-1:0]  poll_q, poll_d;
	piece_t              chunk_q [4];
	logic                chunk_we;

	logic                fire;
	req_t                r;
	logic [LEN_W-1:0]    cnt;
	logic [LEN_W-1:0]    off;
	logic                span;
	logic [LEN_W-1:0]    len1;
	logic [LEN_W-1:0]    n_a, n_b;
	logic [ADDR_W-1:0]   a_b;
	logic [BUF_W-1:0]    b_b;
	logic                split_a, split_b;
	piece_t              p_a0, p_a1, p_b0, p_b1;
	piece_t              new_chunk [4];
	logic [2:0]          new_total;
	logic [1:0]          next_pos;
	logic                next_ok;
	logic                is_request;

	assign req.ready = !queue_full;
	assign fire      = req.valid && req.ready;
	assign r         = req.payload;
	assign is_request = (r.action <= ACT_PRESENCE);

	always_comb begin
		cnt  = (r.byte_count > CNT_W'(PAGE_BYTES)) ? LEN_W'(PAGE_BYTES) : r.byte_count[LEN_W-1:0];
		off  = LEN_W'(r.mem_address[PAGE_BITS-1:0]);
		span = ({1'b0, off} + {1'b0, cnt}) > (LEN_W + 1)'(PAGE_BYTES);
		len1 = LEN_W'(PAGE_BYTES) - off;
		n_a  = span ? len1 : cnt;
		n_b  = cnt - len1;
		a_b  = r.mem_address + ADDR_W'(len1);
		b_b  = r.host_buffer + BUF_W'(len1);
		split_a = (n_a[3:0] == SPLIT_NIBBLE);
		split_b = (n_b[3:0] == SPLIT_NIBBLE);
		p_a0 = '{addr: r.mem_address, len: split_a ? SPLIT_HEAD : n_a, buf_addr: r.host_buffer};
		p_a1 = '{addr: r.mem_address + ADDR_W'(SPLIT_HEAD), len: n_a - SPLIT_HEAD,
			buf_addr: r.host_buffer + BUF_W'(SPLIT_HEAD)};
		p_b0 = '{addr: a_b, len: split_b ? SPLIT_HEAD : n_b, buf_addr: b_b};
		p_b1 = '{addr: a_b + ADDR_W'(SPLIT_HEAD), len: n_b - SPLIT_HEAD,
			buf_addr: b_b + BUF_W'(SPLIT_HEAD)};
		new_chunk[0] = p_a0;
		new_chunk[1] = split_a ? p_a1 : p_b0;
		new_chunk[2] = split_a ? p_b0 : p_b1;
		new_chunk[3] = p_b1;
		new_total = 3'd1 + 3'(split_a) + (span ? 3'd1 + 3'(split_b) : 3'd0);
	end

	assign next_pos = pos_q + 2'd1;
	assign next_ok  = (next_pos != 2'd0) && ({1'b0, next_pos} < total_q);

	always_comb begin
		phase_d    = phase_q;
		total_d    = total_q;
		pos_d      = pos_q;
		poll_d     = poll_q;
		chunk_we   = 1'b0;
		push_valid = 1'b0;
		push_job   = '0;
		if (fire) begin
			if (r.action == ACT_STATUS_REPLY) begin
				unique case (phase_q)
					PH_WPOLL: begin
						push_valid = 1'b1;
						if (r.status_in[ST_WIP_BIT] && (poll_q < poll_limit)) begin
							poll_d         = poll_q + 1'b1;
							push_job.jkind = JOB_RDSR;
						end else if (next_ok) begin
							pos_d          = next_pos;
							poll_d         = '0;
							push_job.jkind = JOB_PIECE;
							push_job.piece = chunk_q[next_pos];
						end else begin
							phase_d        = PH_IDLE;
							pos_d          = 2'd0;
							push_job.jkind = JOB_DONE;
						end
					end
					PH_STATUS: begin
						phase_d         = PH_IDLE;
						push_valid      = 1'b1;
						push_job.jkind  = JOB_DONE;
						push_job.status = r.status_in;
					end
					PH_PRESENCE: begin
						phase_d          = PH_IDLE;
						push_valid       = 1'b1;
						push_job.jkind   = JOB_PRES_END;
						push_job.status  = r.status_in;
						push_job.present = r.status_in[ST_WEL_BIT] && (r.status_in != ST_ALL_ONES);
					end
					default: begin
					end
				endcase
			end else if (is_request) begin
				push_valid = 1'b1;
				if (phase_q != PH_IDLE) begin
					push_job.jkind   = JOB_DONE;
					push_job.refused = 1'b1;
				end else begin
					unique case (r.action)
						ACT_READ: begin
							if (cnt == '0) begin
								push_job.jkind = JOB_DONE;
							end else begin
								push_job.jkind = JOB_READ;
								push_job.piece = '{addr: r.mem_address, len: cnt,
									buf_addr: r.host_buffer};
							end
						end
						ACT_WRITE: begin
							if (cnt == '0) begin
								push_job.jkind = JOB_DONE;
							end else begin
								chunk_we       = 1'b1;
								total_d        = new_total;
								pos_d          = 2'd0;
								poll_d         = '0;
								phase_d        = PH_WPOLL;
								push_job.jkind = JOB_PIECE;
								push_job.piece = p_a0;
							end
						end
						ACT_STATUS: begin
							phase_d        = PH_STATUS;
							push_job.jkind = JOB_RDSR;
						end
						default: begin
							phase_d        = PH_PRESENCE;
							push_job.jkind = JOB_PRES_START;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chunk_we) begin
			for (int i = 0; i < 4; i++) begin
				chunk_q[i] <= new_chunk[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			total_q <= '0;
			pos_q   <= '0;
			poll_q  <= '0;
		end else begin
			phase_q <= phase_d;
			total_q <= total_d;
			pos_q   <= pos_d;
			poll_q  <= poll_d;
		end
	end

	`SESC_ASSERT_NOW(a_busy_refused, fire && is_request && (phase_q != PH_IDLE), push_valid && push_job.refused, "busy request not refused")
	`SESC_ASSERT_NEXT(a_write_enters_poll, fire && (r.action == ACT_WRITE) && (phase_q == PH_IDLE) && (cnt != '0), (phase_q == PH_WPOLL) && (pos_q == 2'd0), "write did not start polling")

endmodule

FILE: rtl/sesc_back.sv
// back end: expands each queued job into result items, one per cycle unless rsp stalls
`include "spi_eeprom_command_sequencer_core_defines.svh"
module sesc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  sesc_pkg::job_t head_job,
	output logic           pop,
	sesc_rsp_if.source     rsp
);
	import sesc_pkg::*;

	job_t       job_q;
	logic       job_valid_q;
	logic [1:0] step_q;
	rsp_t       out_q;
	logic       out_valid_q;
	rsp_t       item;
	logic       load;
	logic       take;
	rsp_t       cmd_read, cmd_write, cmd_wren, cmd_wrdi, cmd_rdsr, done;

	always_comb begin
		cmd_wren = '0;
		cmd_wren.kind = KIND_CMD;
		cmd_wren.opcode = OP_WREN;
		cmd_wrdi = '0;
		cmd_wrdi.kind = KIND_CMD;
		cmd_wrdi.opcode = OP_WRDI;
		cmd_rdsr = '0;
		cmd_rdsr.kind = KIND_CMD;
		cmd_rdsr.opcode = OP_RDSR;
		cmd_rdsr.data_bytes = LEN_W'(1);
		cmd_rdsr.last = 1'b1;
		cmd_read = '0;
		cmd_read.kind = KIND_CMD;
		cmd_read.opcode = OP_READ;
		cmd_read.out_address = job_q.piece.addr;
		cmd_read.data_bytes = job_q.piece.len;
		cmd_read.out_buffer = job_q.piece.buf_addr;
		cmd_write = cmd_read;
		cmd_write.opcode = OP_WRITE;
		done = '0;
		done.kind = KIND_DONE;
		done.status_value = job_q.status;
		done.present = job_q.present;
		done.refused = job_q.refused;
		done.last = 1'b1;

		unique case (job_q.jkind)
			JOB_DONE: item = done;
			JOB_READ: item = (step_q == 2'd0) ? cmd_read : done;
			JOB_RDSR: item = cmd_rdsr;
			JOB_PIECE: begin
				unique case (step_q)
					2'd0: item = cmd_wren;
					2'd1: item = cmd_write;
					2'd2: item = cmd_wrdi;
					default: item = cmd_rdsr;
				endcase
			end
			JOB_PRES_START: item = (step_q == 2'd0) ? cmd_wren : cmd_rdsr;
			JOB_PRES_END: item = (step_q == 2'd0) ? cmd_wrdi : done;
			default: item = done;
		endcase
	end

	assign load = job_valid_q && (!out_valid_q || rsp.ready);
	assign take = !job_valid_q || (load && item.last);
	assign pop  = take && head_valid;

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (load) begin
			out_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				job_valid_q <= head_valid;
				step_q      <= '0;
			end else if (load) begin
				step_q <= step_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SESC_ASSERT_NOW(a_idle_step_zero, !job_valid_q, step_q == 2'd0, "step left over without a job")

endmodule
